### design/tcg_pkg.sv
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared types, constants and helper functions of the tenant concurrency gate.
// ----------------------------------------------------------------------------
package tcg_pkg;

  localparam int NUM_TENANTS  = 64;
  localparam int NUM_CLASSES  = 4;
  localparam int COUNT_WIDTH  = 16;

  localparam int TENANT_AW    = (NUM_TENANTS > 1) ? $clog2(NUM_TENANTS) : 1;
  localparam int CLASS_AW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  // One tenant table entry holds the run count above the task count.
  localparam int ENTRY_W      = 2 * COUNT_WIDTH;

  localparam int OP_W         = 3;
  localparam int TENANT_W     = 6;
  localparam int CLASS_W      = 2;
  localparam int FIELD_W      = 16;
  localparam int EV_W         = 32;
  localparam int NUM_EVENTS   = 5;
  localparam int NUM_CAP_REGS = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int CMP_W        = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;

  // Event counter slots.
  localparam int EV_ADMIT   = 0;
  localparam int EV_REJECT  = 1;
  localparam int EV_ACQUIRE = 2;
  localparam int EV_DEFER   = 3;
  localparam int EV_RELEASE = 4;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_DATA_W-1:0]  limit_t;
  typedef logic [EV_W-1:0]        event_cnt_t;
  typedef logic [NUM_EVENTS-1:0][EV_W-1:0] events_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT        = 3'd0,
    OP_READMIT      = 3'd1,
    OP_RELEASE_RUN  = 3'd2,
    OP_ACQUIRE      = 3'd3,
    OP_RELEASE_TASK = 3'd4,
    OP_REACQUIRE    = 3'd5,
    OP_QUERY        = 3'd6
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUNS_PER_TENANT  = 3'd0,
    REG_RUNS_GLOBAL      = 3'd1,
    REG_TASKS_PER_TENANT = 3'd2,
    REG_CLASS0_CAP       = 3'd3,
    REG_CLASS1_CAP       = 3'd4,
    REG_CLASS2_CAP       = 3'd5,
    REG_CLASS3_CAP       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    limit_t                                  runs_per_tenant;
    limit_t                                  runs_global;
    limit_t                                  tasks_per_tenant;
    logic [NUM_CAP_REGS-1:0][CFG_DATA_W-1:0] class_cap;
  } limits_t;

  typedef struct packed {
    count_t tenant_runs;
    count_t tenant_tasks;
    count_t class_tasks;
    count_t global_runs;
    count_t run_peak;
  } counts_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [TENANT_W-1:0] tenant;
    logic [CLASS_W-1:0]  resource_class;
  } in_item_t;

  typedef struct packed {
    logic               granted;
    logic [FIELD_W-1:0] tenant_runs;
    logic [FIELD_W-1:0] tenant_tasks;
    logic [FIELD_W-1:0] class_tasks;
    logic [FIELD_W-1:0] total_runs;
    logic [FIELD_W-1:0] peak_runs;
    logic [EV_W-1:0]    admitted_count;
    logic [EV_W-1:0]    rejected_count;
    logic [EV_W-1:0]    acquired_count;
    logic [EV_W-1:0]    deferred_count;
    logic [EV_W-1:0]    released_count;
  } out_item_t;

  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic count_t floor_dec(count_t v);
    return (v == '0) ? v : v - count_t'(1);
  endfunction

  function automatic event_cnt_t ev_inc(event_cnt_t v);
    return (v == '1) ? v : v + event_cnt_t'(1);
  endfunction

  // A limit of zero means the check never fails.
  function automatic logic over_limit(count_t cnt, limit_t lim);
    return (lim != '0) && (CMP_W'(cnt) >= CMP_W'(lim));
  endfunction

endpackage

### design/tcg_ram.sv
// ----------------------------------------------------------------------------
// tcg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/tcg_cfg.sv
// ----------------------------------------------------------------------------
// tcg_cfg
// Limit and capacity register file written through the configuration port.
// ----------------------------------------------------------------------------
module tcg_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tcg_pkg::limits_t                 limits
);

  tcg_pkg::limits_t lim_r;
  tcg_pkg::limits_t lim_nxt;

  always_comb begin
    lim_nxt = lim_r;
    if (cfg_we) begin
      case (cfg_index)
        tcg_pkg::REG_RUNS_PER_TENANT:  lim_nxt.runs_per_tenant  = cfg_data;
        tcg_pkg::REG_RUNS_GLOBAL:      lim_nxt.runs_global      = cfg_data;
        tcg_pkg::REG_TASKS_PER_TENANT: lim_nxt.tasks_per_tenant = cfg_data;
        tcg_pkg::REG_CLASS0_CAP:       lim_nxt.class_cap[0]     = cfg_data;
        tcg_pkg::REG_CLASS1_CAP:       lim_nxt.class_cap[1]     = cfg_data;
        tcg_pkg::REG_CLASS2_CAP:       lim_nxt.class_cap[2]     = cfg_data;
        tcg_pkg::REG_CLASS3_CAP:       lim_nxt.class_cap[3]     = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= '0;
    end else begin
      lim_r <= lim_nxt;
    end
  end

  assign limits = lim_r;

endmodule

### design/tcg_update.sv
// ----------------------------------------------------------------------------
// tcg_update
// Decision and count update for one request, given the counts it touches.
// ----------------------------------------------------------------------------
module tcg_update (
  input  logic [tcg_pkg::OP_W-1:0]    op,
  input  logic                        t_ok,
  input  logic                        c_ok,
  input  tcg_pkg::limits_t            limits,
  input  tcg_pkg::limit_t             class_cap,
  input  tcg_pkg::counts_t            cur,
  input  tcg_pkg::events_t            ev_cur,
  output tcg_pkg::counts_t            nxt,
  output tcg_pkg::events_t            ev_nxt,
  output logic                        granted
);

  tcg_pkg::count_t glob_inc;

  assign glob_inc = tcg_pkg::sat_inc(cur.global_runs);

  always_comb begin
    nxt     = cur;
    ev_nxt  = ev_cur;
    granted = 1'b0;
    if (t_ok) begin
      case (op)
        tcg_pkg::OP_ADMIT: begin
          if (tcg_pkg::over_limit(cur.tenant_runs, limits.runs_per_tenant) ||
              tcg_pkg::over_limit(cur.global_runs, limits.runs_global)) begin
            ev_nxt[tcg_pkg::EV_REJECT] = tcg_pkg::ev_inc(ev_cur[tcg_pkg::EV_REJECT]);
          end else begin
            nxt.tenant_runs = tcg_pkg::sat_inc(cur.tenant_runs);
            nxt.global_runs = glob_inc;
            if (glob_inc > cur.run_peak) begin
              nxt.run_peak = glob_inc;
            end
            ev_nxt[tcg_pkg::EV_ADMIT] = tcg_pkg::ev_inc(ev_cur[tcg_pkg::EV_ADMIT]);
            granted = 1'b1;
          end
        end
        tcg_pkg::OP_READMIT: begin
          nxt.tenant_runs = tcg_pkg::sat_inc(cur.tenant_runs);
          nxt.global_runs = glob_inc;
          if (glob_inc > cur.run_peak) begin
            nxt.run_peak = glob_inc;
          end
        end
        tcg_pkg::OP_RELEASE_RUN: begin
          // Only a tenant that holds a run gives one back to the global count.
          if (cur.tenant_runs != '0) begin
            nxt.tenant_runs = cur.tenant_runs - tcg_pkg::count_t'(1);
            nxt.global_runs = tcg_pkg::floor_dec(cur.global_runs);
          end
        end
        tcg_pkg::OP_ACQUIRE: begin
          if (c_ok) begin
            if (tcg_pkg::over_limit(cur.tenant_tasks, limits.tasks_per_tenant) ||
                tcg_pkg::over_limit(cur.class_tasks, class_cap)) begin
              ev_nxt[tcg_pkg::EV_DEFER] = tcg_pkg::ev_inc(ev_cur[tcg_pkg::EV_DEFER]);
            end else begin
              nxt.tenant_tasks = tcg_pkg::sat_inc(cur.tenant_tasks);
              nxt.class_tasks  = tcg_pkg::sat_inc(cur.class_tasks);
              ev_nxt[tcg_pkg::EV_ACQUIRE] = tcg_pkg::ev_inc(ev_cur[tcg_pkg::EV_ACQUIRE]);
              granted = 1'b1;
            end
          end
        end
        tcg_pkg::OP_RELEASE_TASK: begin
          if (c_ok) begin
            nxt.tenant_tasks = tcg_pkg::floor_dec(cur.tenant_tasks);
            nxt.class_tasks  = tcg_pkg::floor_dec(cur.class_tasks);
            ev_nxt[tcg_pkg::EV_RELEASE] = tcg_pkg::ev_inc(ev_cur[tcg_pkg::EV_RELEASE]);
          end
        end
        tcg_pkg::OP_REACQUIRE: begin
          if (c_ok) begin
            nxt.tenant_tasks = tcg_pkg::sat_inc(cur.tenant_tasks);
            nxt.class_tasks  = tcg_pkg::sat_inc(cur.class_tasks);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### design/tenant_concurrency_gate.sv
// ----------------------------------------------------------------------------
// tenant_concurrency_gate
// Run and task admission gate across tenants and resource classes.
// ----------------------------------------------------------------------------
// The gate takes one request per cycle while its input is not stalled and
// returns one result word per request: the word is held in the output
// register until it is taken at an edge when the output is not stalled. The
// per-tenant run and task counts live in a RAM with a registered read; the
// lookup stage reads the tenant's entry, then the gate decides, updates the
// counts and loads the output register. A write-to-read bypass and one valid
// bit per tenant (cleared by reset) keep back-to-back requests to the same
// tenant exact, so no clearing pass is needed after reset. Configuration
// writes take effect on the next request and must be made while idle.
// ----------------------------------------------------------------------------
module tenant_concurrency_gate (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tcg_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tcg_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [tcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tcg_pkg::limits_t limits;

  // Lookup stage.
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  tcg_pkg::in_item_t     s1_item_r;
  logic                  in_accept;
  logic                  fire;

  // Tenant table.
  logic [tcg_pkg::NUM_TENANTS-1:0] tvalid_r;
  logic [tcg_pkg::NUM_TENANTS-1:0] tvalid_nxt;
  logic [tcg_pkg::ENTRY_W-1:0]     ram_rdata;
  logic [tcg_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [tcg_pkg::TENANT_AW-1:0]   rd_addr;
  logic [tcg_pkg::TENANT_AW-1:0]   s1_addr;
  logic                            lw_valid_r;
  logic [tcg_pkg::TENANT_AW-1:0]   lw_addr_r;
  logic [tcg_pkg::ENTRY_W-1:0]     lw_data_r;
  logic [tcg_pkg::ENTRY_W-1:0]     entry;

  // Counters held in flops.
  tcg_pkg::count_t  class_cnt_r [tcg_pkg::NUM_CLASSES];
  tcg_pkg::count_t  glob_r;
  tcg_pkg::count_t  peak_r;
  tcg_pkg::events_t ev_r;

  logic                            t_ok;
  logic                            c_ok;
  logic [tcg_pkg::CLASS_AW-1:0]    cidx;
  tcg_pkg::limit_t                 cap_sel;
  tcg_pkg::counts_t                cur;
  tcg_pkg::counts_t                nxt;
  tcg_pkg::events_t                ev_nxt;
  logic                            granted;

  logic                            out_valid_r;
  logic                            out_valid_nxt;
  tcg_pkg::out_item_t              out_data_r;
  tcg_pkg::out_item_t              out_data_nxt;

  tcg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  assign fire      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  assign rd_addr = tcg_pkg::TENANT_AW'(in_data.tenant);
  assign s1_addr = tcg_pkg::TENANT_AW'(s1_item_r.tenant);

  assign t_ok = int'(s1_item_r.tenant) < tcg_pkg::NUM_TENANTS;
  assign c_ok = int'(s1_item_r.resource_class) < tcg_pkg::NUM_CLASSES;
  assign cidx = tcg_pkg::CLASS_AW'(s1_item_r.resource_class);

  tcg_ram #(
    .WIDTH (tcg_pkg::ENTRY_W),
    .DEPTH (tcg_pkg::NUM_TENANTS)
  ) u_tenant_ram (
    .clk   (clk),
    .we    (fire && t_ok),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // The RAM read may have raced the write of the request just ahead, so the
  // last written entry takes precedence; never-written entries read as zero.
  always_comb begin
    if (lw_valid_r && (lw_addr_r == s1_addr)) begin
      entry = lw_data_r;
    end else if (tvalid_r[s1_addr]) begin
      entry = ram_rdata;
    end else begin
      entry = '0;
    end
  end

  always_comb begin
    cur.tenant_runs  = entry[tcg_pkg::ENTRY_W-1:tcg_pkg::COUNT_WIDTH];
    cur.tenant_tasks = entry[tcg_pkg::COUNT_WIDTH-1:0];
    cur.class_tasks  = c_ok ? class_cnt_r[cidx] : '0;
    cur.global_runs  = glob_r;
    cur.run_peak     = peak_r;
    cap_sel          = limits.class_cap[s1_item_r.resource_class];
  end

  tcg_update u_update (
    .op        (s1_item_r.op),
    .t_ok      (t_ok),
    .c_ok      (c_ok),
    .limits    (limits),
    .class_cap (cap_sel),
    .cur       (cur),
    .ev_cur    (ev_r),
    .nxt       (nxt),
    .ev_nxt    (ev_nxt),
    .granted   (granted)
  );

  assign ram_wdata = {nxt.tenant_runs, nxt.tenant_tasks};

  always_comb begin
    tvalid_nxt = tvalid_r;
    if (fire && t_ok) begin
      tvalid_nxt[s1_addr] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt.granted        = granted;
    out_data_nxt.tenant_runs    = t_ok ? tcg_pkg::FIELD_W'(nxt.tenant_runs) : '0;
    out_data_nxt.tenant_tasks   = t_ok ? tcg_pkg::FIELD_W'(nxt.tenant_tasks) : '0;
    out_data_nxt.class_tasks    = c_ok ? tcg_pkg::FIELD_W'(nxt.class_tasks) : '0;
    out_data_nxt.total_runs     = tcg_pkg::FIELD_W'(nxt.global_runs);
    out_data_nxt.peak_runs      = tcg_pkg::FIELD_W'(nxt.run_peak);
    out_data_nxt.admitted_count = ev_nxt[tcg_pkg::EV_ADMIT];
    out_data_nxt.rejected_count = ev_nxt[tcg_pkg::EV_REJECT];
    out_data_nxt.acquired_count = ev_nxt[tcg_pkg::EV_ACQUIRE];
    out_data_nxt.deferred_count = ev_nxt[tcg_pkg::EV_DEFER];
    out_data_nxt.released_count = ev_nxt[tcg_pkg::EV_RELEASE];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tvalid_r    <= '0;
      lw_valid_r  <= 1'b0;
      glob_r      <= '0;
      peak_r      <= '0;
      ev_r        <= '0;
      for (int i = 0; i < tcg_pkg::NUM_CLASSES; i++) begin
        class_cnt_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      tvalid_r    <= tvalid_nxt;
      if (fire) begin
        glob_r <= nxt.global_runs;
        peak_r <= nxt.run_peak;
        ev_r   <= ev_nxt;
        if (c_ok) begin
          class_cnt_r[cidx] <= nxt.class_tasks;
        end
        if (t_ok) begin
          lw_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (fire && t_ok) begin
      lw_addr_r <= s1_addr;
      lw_data_r <= ram_wdata;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tenant concurrency gate. Requests go in one word
// at a time while a predictor mirrors every tenant, class, run and event count.
// Each result word is checked field by field against the oldest prediction.
// Directed requests cover each operation and limit case. Random traffic then
// runs under several limit settings and idle patterns, a long output hold, a
// sender pause, and limits at their largest value.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tcg_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int LATENCY = 2;
  localparam int unsigned CYCLE_LIMIT = 100_000;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  tcg_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tcg_pkg::out_item_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [tcg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tcg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  tenant_concurrency_gate u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the gate: limits, counts and event tallies.
  tcg_pkg::limit_t     lim_run_tenant = '0;
  tcg_pkg::limit_t     lim_run_all = '0;
  tcg_pkg::limit_t     lim_task_tenant = '0;
  tcg_pkg::limit_t     class_cap [tcg_pkg::NUM_CLASSES] = '{default: '0};
  tcg_pkg::count_t     runs_of [tcg_pkg::NUM_TENANTS] = '{default: '0};
  tcg_pkg::count_t     tasks_of [tcg_pkg::NUM_TENANTS] = '{default: '0};
  tcg_pkg::count_t     class_load [tcg_pkg::NUM_CLASSES] = '{default: '0};
  tcg_pkg::count_t     run_total = '0;
  tcg_pkg::count_t     run_high = '0;
  tcg_pkg::event_cnt_t event_tally [tcg_pkg::NUM_EVENTS] = '{default: '0};

  tcg_pkg::out_item_t pending_results [$];
  tcg_pkg::out_item_t expected_word;
  int                 error_count = 0;
  int                 in_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_request = 0;
  int                 hold_left = 0;
  int unsigned        cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic tcg_pkg::count_t count_up(tcg_pkg::count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic tcg_pkg::count_t count_down(tcg_pkg::count_t v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic tcg_pkg::event_cnt_t event_up(tcg_pkg::event_cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic bit limit_hit(tcg_pkg::count_t n, tcg_pkg::limit_t lim);
    return (lim != '0) && (n >= lim);
  endfunction

  // Applies one request to the mirror and returns the word the gate must give.
  function automatic tcg_pkg::out_item_t gate_predict(tcg_pkg::in_item_t req);
    tcg_pkg::out_item_t res;
    int t;
    int c;
    res = '0;
    t = int'(req.tenant);
    c = int'(req.resource_class);
    case (req.op)
      tcg_pkg::OP_ADMIT, tcg_pkg::OP_READMIT: begin
        if (req.op == tcg_pkg::OP_ADMIT &&
            (limit_hit(runs_of[t], lim_run_tenant) ||
             limit_hit(run_total, lim_run_all))) begin
          event_tally[tcg_pkg::EV_REJECT] = event_up(event_tally[tcg_pkg::EV_REJECT]);
        end else begin
          runs_of[t] = count_up(runs_of[t]);
          run_total = count_up(run_total);
          if (run_total > run_high) run_high = run_total;
          if (req.op == tcg_pkg::OP_ADMIT) begin
            event_tally[tcg_pkg::EV_ADMIT] = event_up(event_tally[tcg_pkg::EV_ADMIT]);
            res.granted = 1'b1;
          end
        end
      end
      tcg_pkg::OP_RELEASE_RUN: begin
        if (runs_of[t] != '0) begin
          runs_of[t] = runs_of[t] - 1'b1;
          run_total = count_down(run_total);
        end
      end
      tcg_pkg::OP_ACQUIRE, tcg_pkg::OP_REACQUIRE: begin
        if (req.op == tcg_pkg::OP_ACQUIRE &&
            (limit_hit(tasks_of[t], lim_task_tenant) ||
             limit_hit(class_load[c], class_cap[c]))) begin
          event_tally[tcg_pkg::EV_DEFER] = event_up(event_tally[tcg_pkg::EV_DEFER]);
        end else begin
          tasks_of[t] = count_up(tasks_of[t]);
          class_load[c] = count_up(class_load[c]);
          if (req.op == tcg_pkg::OP_ACQUIRE) begin
            event_tally[tcg_pkg::EV_ACQUIRE] = event_up(event_tally[tcg_pkg::EV_ACQUIRE]);
            res.granted = 1'b1;
          end
        end
      end
      tcg_pkg::OP_RELEASE_TASK: begin
        tasks_of[t] = count_down(tasks_of[t]);
        class_load[c] = count_down(class_load[c]);
        event_tally[tcg_pkg::EV_RELEASE] = event_up(event_tally[tcg_pkg::EV_RELEASE]);
      end
      default: begin
      end
    endcase
    res.tenant_runs    = runs_of[t];
    res.tenant_tasks   = tasks_of[t];
    res.class_tasks    = class_load[c];
    res.total_runs     = run_total;
    res.peak_runs      = run_high;
    res.admitted_count = event_tally[tcg_pkg::EV_ADMIT];
    res.rejected_count = event_tally[tcg_pkg::EV_REJECT];
    res.acquired_count = event_tally[tcg_pkg::EV_ACQUIRE];
    res.deferred_count = event_tally[tcg_pkg::EV_DEFER];
    res.released_count = event_tally[tcg_pkg::EV_RELEASE];
    return res;
  endfunction

  task automatic report_field(string fname, logic [tcg_pkg::EV_W-1:0] want,
                              logic [tcg_pkg::EV_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word: expected none, actual %h", $time, out_data);
      end else begin
        expected_word = pending_results.pop_front();
        report_field("granted", tcg_pkg::EV_W'(expected_word.granted),
                     tcg_pkg::EV_W'(out_data.granted));
        report_field("tenant_runs", tcg_pkg::EV_W'(expected_word.tenant_runs),
                     tcg_pkg::EV_W'(out_data.tenant_runs));
        report_field("tenant_tasks", tcg_pkg::EV_W'(expected_word.tenant_tasks),
                     tcg_pkg::EV_W'(out_data.tenant_tasks));
        report_field("class_tasks", tcg_pkg::EV_W'(expected_word.class_tasks),
                     tcg_pkg::EV_W'(out_data.class_tasks));
        report_field("total_runs", tcg_pkg::EV_W'(expected_word.total_runs),
                     tcg_pkg::EV_W'(out_data.total_runs));
        report_field("peak_runs", tcg_pkg::EV_W'(expected_word.peak_runs),
                     tcg_pkg::EV_W'(out_data.peak_runs));
        report_field("admitted_count", expected_word.admitted_count, out_data.admitted_count);
        report_field("rejected_count", expected_word.rejected_count, out_data.rejected_count);
        report_field("acquired_count", expected_word.acquired_count, out_data.acquired_count);
        report_field("deferred_count", expected_word.deferred_count, out_data.deferred_count);
        report_field("released_count", expected_word.released_count, out_data.released_count);
      end
    end
  end

  // Output stall: random per cycle, or a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_request > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_request - 1;
      hold_request = 0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one request word and returns at the edge that accepts it.
  task automatic send_request(logic [tcg_pkg::OP_W-1:0] op, int unsigned tenant,
                              int unsigned cls);
    tcg_pkg::in_item_t req;
    int gap;
    req.op = op;
    req.tenant = tcg_pkg::TENANT_W'(tenant);
    req.resource_class = tcg_pkg::CLASS_W'(cls);
    gap = 0;
    while ($urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(gate_predict(req));
  endtask

  // Tenants mostly come from a small group so that limits are reached.
  task automatic send_random(int span);
    logic [tcg_pkg::OP_W-1:0] op;
    int unsigned tenant;
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) op = tcg_pkg::OP_ADMIT;
    else if (r < 30) op = tcg_pkg::OP_READMIT;
    else if (r < 50) op = tcg_pkg::OP_RELEASE_RUN;
    else if (r < 72) op = tcg_pkg::OP_ACQUIRE;
    else if (r < 90) op = tcg_pkg::OP_RELEASE_TASK;
    else if (r < 93) op = tcg_pkg::OP_REACQUIRE;
    else if (r < 98) op = tcg_pkg::OP_QUERY;
    else op = OP_UNUSED;
    if ($urandom_range(0, 9) == 0) tenant = $urandom_range(0, tcg_pkg::NUM_TENANTS - 1);
    else tenant = $urandom_range(0, span - 1);
    send_request(op, tenant, $urandom_range(0, tcg_pkg::NUM_CLASSES - 1));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_limits(tcg_pkg::limit_t runs_tenant, tcg_pkg::limit_t runs_all,
                            tcg_pkg::limit_t tasks_tenant, tcg_pkg::limit_t cap0,
                            tcg_pkg::limit_t cap1, tcg_pkg::limit_t cap2,
                            tcg_pkg::limit_t cap3);
    tcg_pkg::cfg_reg_t regs [7];
    tcg_pkg::limit_t vals [7];
    regs = '{tcg_pkg::REG_RUNS_PER_TENANT, tcg_pkg::REG_RUNS_GLOBAL,
             tcg_pkg::REG_TASKS_PER_TENANT, tcg_pkg::REG_CLASS0_CAP,
             tcg_pkg::REG_CLASS1_CAP, tcg_pkg::REG_CLASS2_CAP, tcg_pkg::REG_CLASS3_CAP};
    vals = '{runs_tenant, runs_all, tasks_tenant, cap0, cap1, cap2, cap3};
    wait_results_done();
    repeat (LATENCY + 2) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    lim_run_tenant = runs_tenant;
    lim_run_all = runs_all;
    lim_task_tenant = tasks_tenant;
    class_cap = '{cap0, cap1, cap2, cap3};
  endtask

  task automatic test_basic_ops();
    send_request(tcg_pkg::OP_QUERY, 0, 0);
    send_request(OP_UNUSED, tcg_pkg::NUM_TENANTS - 1, 3);
    send_request(tcg_pkg::OP_ADMIT, tcg_pkg::NUM_TENANTS - 1, 0);
    send_request(tcg_pkg::OP_READMIT, tcg_pkg::NUM_TENANTS - 1, 1);
    send_request(tcg_pkg::OP_RELEASE_RUN, tcg_pkg::NUM_TENANTS - 1, 2);
    // Releasing a run of a tenant that has none changes nothing.
    send_request(tcg_pkg::OP_RELEASE_RUN, 0, 0);
    send_request(tcg_pkg::OP_ACQUIRE, 0, 3);
    send_request(tcg_pkg::OP_REACQUIRE, tcg_pkg::NUM_TENANTS - 1, 3);
    send_request(tcg_pkg::OP_RELEASE_TASK, 0, 3);
    // Both counts already at zero: they stay there but the release is counted.
    send_request(tcg_pkg::OP_RELEASE_TASK, 0, 0);
    send_request(tcg_pkg::OP_QUERY, tcg_pkg::NUM_TENANTS - 1, 3);
  endtask

  task automatic test_limit_checks();
    set_limits(16'd1, 16'd2, 16'd1, 16'd1, 16'd2, 16'd3, 16'd0);
    send_request(tcg_pkg::OP_ADMIT, 1, 0);
    send_request(tcg_pkg::OP_ADMIT, 1, 0);
    send_request(tcg_pkg::OP_ADMIT, 2, 0);
    send_request(tcg_pkg::OP_READMIT, 2, 0);
    send_request(tcg_pkg::OP_RELEASE_RUN, 2, 0);
    send_request(tcg_pkg::OP_ACQUIRE, 1, 0);
    send_request(tcg_pkg::OP_ACQUIRE, 1, 1);
    send_request(tcg_pkg::OP_ACQUIRE, 2, 0);
    send_request(tcg_pkg::OP_ACQUIRE, 2, 3);
    send_request(tcg_pkg::OP_REACQUIRE, 1, 0);
    send_request(tcg_pkg::OP_RELEASE_TASK, 1, 0);
    send_request(tcg_pkg::OP_RELEASE_TASK, 1, 0);
    send_request(tcg_pkg::OP_QUERY, 1, 0);
  endtask

  task automatic test_random_traffic(int count, int idle, int stall, int span);
    in_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_random(span);
  endtask

  // The output holds off long enough for the gate to fill and stall its input.
  task automatic test_backpressure();
    set_limits(16'd3, 16'd12, 16'd2, 16'd2, 16'd3, 16'd4, 16'd5);
    in_idle_pct = 0;
    stall_pct = 0;
    hold_request = 120;
    repeat (60) send_random(8);
  endtask

  task automatic test_sender_pause();
    in_idle_pct = 0;
    stall_pct = 75;
    repeat (40) send_random(8);
    wait_results_done();
    repeat (40) send_random(8);
  endtask

  // Limits at their largest value never refuse at the counts reached here.
  task automatic test_max_limits();
    set_limits('1, '1, '1, '1, '1, '1, '1);
    in_idle_pct = 0;
    stall_pct = 0;
    send_request(tcg_pkg::OP_ADMIT, 9, 0);
    send_request(tcg_pkg::OP_ACQUIRE, 9, 2);
    send_request(tcg_pkg::OP_ACQUIRE, 10, 2);
    send_request(tcg_pkg::OP_RELEASE_RUN, 9, 0);
    send_request(tcg_pkg::OP_RELEASE_TASK, 9, 2);
    send_request(tcg_pkg::OP_QUERY, 9, 2);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_limit_checks();
    set_limits('1, '1, '1, '1, '1, '1, '1);
    test_random_traffic(250, 0, 0, tcg_pkg::NUM_TENANTS);
    set_limits(tcg_pkg::limit_t'($urandom_range(1, 3)), tcg_pkg::limit_t'($urandom_range(2, 10)),
               tcg_pkg::limit_t'($urandom_range(1, 3)), tcg_pkg::limit_t'($urandom_range(1, 4)),
               tcg_pkg::limit_t'($urandom_range(1, 4)), tcg_pkg::limit_t'($urandom_range(1, 4)),
               tcg_pkg::limit_t'($urandom_range(1, 4)));
    test_random_traffic(250, 75, 0, 8);
    set_limits(16'd2, 16'd0, 16'd0, 16'd3, 16'd0, 16'd1, 16'd0);
    test_random_traffic(250, 0, 75, 4);
    set_limits(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    test_random_traffic(250, 14, 14, 16);
    set_limits('0, '0, '0, '0, '0, '0, '0);
    test_random_traffic(230, 0, 0, 8);
    test_backpressure();
    test_sender_pause();
    test_max_limits();
    wait_results_done();
    repeat (4 * LATENCY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
